### hdl/smf_pkg.sv
// Shared types, constants and helpers of the sliding median filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package smf_pkg;

  localparam int MAX_WINDOW = 31;
  localparam int MIN_WINDOW = 3;
  localparam int SMP_W      = 16;
  localparam int WIN_W      = 5;
  localparam int FILL_W     = 6;
  localparam int IDX_W      = $clog2(MAX_WINDOW);
  localparam int WCNT_W     = $clog2(MAX_WINDOW + 1);

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [WCNT_W-1:0]       wcnt_t;

  // Control broadcast from the sequencer to every stage of the chain.
  typedef struct packed {
    logic    shift;
    logic    cnt;
    sample_t bval;
    idx_t    bidx;
    wcnt_t   win;
    idx_t    half;
  } stage_ctrl_t;

  // Adjust the requested window: zero disables, small values become the
  // minimum, even values round up, and the result is limited to an odd
  // value no larger than the chain length.
  function automatic wcnt_t eff_window(input logic [WIN_W-1:0] req);
    logic [WIN_W:0] t;
    t = {1'b0, req};
    if (req == '0) begin
      t = '0;
    end else begin
      if (t < (WIN_W+1)'(MIN_WINDOW)) t = (WIN_W+1)'(MIN_WINDOW);
      if (!t[0]) t = t + (WIN_W+1)'(1);
      if (t > (WIN_W+1)'(MAX_WINDOW)) begin
        t = (WIN_W+1)'(MAX_WINDOW);
        if (!t[0]) t = t - (WIN_W+1)'(1);
      end
    end
    return WCNT_W'(t);
  endfunction

endpackage

`default_nettype wire

### hdl/smf_cell.sv
// One stage of the sample chain: holds a sample and its rank in the window.
// Depends on smf_pkg.
`default_nettype none

module smf_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  smf_pkg::idx_t        idx_i,
  input  smf_pkg::stage_ctrl_t ctrl_i,
  input  smf_pkg::sample_t     prev_i,
  output smf_pkg::sample_t     sample_o,
  output logic                 match_o
);
  import smf_pkg::*;

  sample_t sample_q;
  idx_t    rank_q, rank_d;
  logic    active;
  logic    below;

  assign active = WCNT_W'(idx_i) < ctrl_i.win;
  // Ties are broken by position, so every rank in the window is unique.
  assign below  = (ctrl_i.bval < sample_q) ||
                  ((ctrl_i.bval == sample_q) && (ctrl_i.bidx < idx_i));

  always_comb begin
    rank_d = rank_q;
    if (ctrl_i.shift) begin
      rank_d = '0;
    end else if (ctrl_i.cnt && below) begin
      rank_d = rank_q + idx_t'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sample_q <= prev_i;
    end
    rank_q <= rank_d;
  end

  assign sample_o = sample_q;
  assign match_o  = active && (rank_q == ctrl_i.half);

  // rst_ni is unused by the payload-only stage; keep it for a uniform port set
  logic unused_rst;
  assign unused_rst = rst_ni;

endmodule

`default_nettype wire

### hdl/smf_chain.sv
// Row of sample stages with a read port and median selection.
// Depends on smf_pkg and smf_cell.
`default_nettype none

module smf_chain (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  smf_pkg::stage_ctrl_t ctrl_i,
  input  smf_pkg::sample_t     new_i,
  input  smf_pkg::idx_t        rd_idx_i,
  output smf_pkg::sample_t     rd_data_o,
  output smf_pkg::sample_t     med_o,
  output logic [smf_pkg::MAX_WINDOW-1:0] match_o
);
  import smf_pkg::*;

  sample_t samples [MAX_WINDOW];

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_stage
    sample_t prev;
    if (i == 0) begin : g_head
      assign prev = new_i;
    end else begin : g_link
      assign prev = samples[i-1];
    end
    smf_cell u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (idx_t'(i)),
      .ctrl_i   (ctrl_i),
      .prev_i   (prev),
      .sample_o (samples[i]),
      .match_o  (match_o[i])
    );
  end

  always_comb begin
    rd_data_o = '0;
    med_o     = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (rd_idx_i == idx_t'(i)) rd_data_o = samples[i];
      if (match_o[i]) med_o = med_o | samples[i];
    end
  end

endmodule

`default_nettype wire

### hdl/sliding_median_filter.sv
// Top level of the streaming 1-D median filter with an odd centred window.
// Depends on smf_pkg and smf_chain (which instantiates smf_cell).
//
// Usage:
//   Samples enter on the s_axis channel (tdata = sample, tlast ends a
//   sequence); results leave on m_axis (tdata = value, tuser = raw flag,
//   tlast = final result of the sequence). The window register is written
//   on the cfg channel, which is always ready; write it only while idle.
//   Window 0 drops every input transaction with no result.
//   Steps per accepted sample, window w and half window h = w >> 1:
//     - raw pass-through at the head of a sequence: accept, then load;
//     - window filled: accept, rank counting over all w samples of the
//       window (one broadcast sample per cycle), then emit the median;
//     - on tlast: each further raw sample (up to h) is flushed in turn.
//   The input is ready only while idle, so a new sample is accepted only
//   after the last one is fully processed, rank counting included.
//   Reset clears the sequencer, fill count and output valid flag and sets the
//   window to 3; stored samples stay undefined until written.
//   A stalled receiver holds the output register; the block keeps working
//   on the next transaction and waits only when a further result is ready.
`default_nettype none

module sliding_median_filter (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration: requested window length
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [smf_pkg::WIN_W-1:0]  cfg_data_i,
  // input stream
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [15:0]                s_axis_tdata,   // [15:0] sample
  input  wire                        s_axis_tlast,   // last
  // output stream
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [15:0]                m_axis_tdata,   // [15:0] value
  output logic                       m_axis_tuser,   // [0] raw
  output logic                       m_axis_tlast    // last_res
);
  import smf_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PASS  = 3'd1;
  localparam logic [2:0] ST_RANK  = 3'd2;
  localparam logic [2:0] ST_MED   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [WIN_W-1:0]  win_req_q;
  wcnt_t             w_q, w_d;
  idx_t              k_q, k_d;
  idx_t              d_q, d_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              last_q, last_d;

  logic    out_valid_q, out_valid_d;
  sample_t out_data_q, out_data_d;
  logic    out_raw_q, out_raw_d;
  logic    out_last_q, out_last_d;

  wcnt_t             w_eff;
  idx_t              h_eff, h_q;
  logic [FILL_W-1:0] c_new;
  logic              take;
  logic              out_free;
  logic              out_load;

  stage_ctrl_t ctrl;
  idx_t        rd_idx;
  sample_t     rd_data;
  sample_t     med;
  logic [MAX_WINDOW-1:0] match;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign w_eff = eff_window(win_req_q);
  assign h_eff = idx_t'(w_eff >> 1);
  assign h_q   = idx_t'(w_q >> 1);
  assign take  = s_axis_tvalid && s_axis_tready && (w_eff != '0);
  assign c_new = (fill_q == '1) ? fill_q : fill_q + FILL_W'(1);

  assign out_free = !out_valid_q || m_axis_tready;

  // Broadcast control to the stage row
  always_comb begin
    ctrl       = '0;
    ctrl.shift = take;
    ctrl.cnt   = (state_q == ST_RANK);
    ctrl.bval  = rd_data;
    ctrl.bidx  = k_q;
    ctrl.win   = w_q;
    ctrl.half  = h_q;
  end

  always_comb begin
    unique case (state_q)
      ST_PASS:  rd_idx = '0;
      ST_FLUSH: rd_idx = d_q - idx_t'(1);
      default:  rd_idx = k_q;
    endcase
  end

  smf_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .new_i     (sample_t'(s_axis_tdata)),
    .rd_idx_i  (rd_idx),
    .rd_data_o (rd_data),
    .med_o     (med),
    .match_o   (match)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    w_d        = w_q;
    k_d        = k_q;
    d_d        = d_q;
    fill_d     = fill_q;
    last_d     = last_q;
    out_load   = 1'b0;
    out_data_d = out_data_q;
    out_raw_d  = out_raw_q;
    out_last_d = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          w_d    = w_eff;
          last_d = s_axis_tlast;
          k_d    = '0;
          fill_d = s_axis_tlast ? '0 : c_new;
          if (c_new <= FILL_W'(h_eff)) begin
            state_d = ST_PASS;
          end else if (c_new >= FILL_W'(w_eff)) begin
            state_d = ST_RANK;
          end else if (s_axis_tlast) begin
            // short sequence: flush what has not passed through yet
            d_d     = idx_t'(c_new - FILL_W'(h_eff));
            state_d = ST_FLUSH;
          end
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = rd_data;
          out_raw_d  = 1'b1;
          out_last_d = last_q;
          state_d    = ST_IDLE;
        end
      end
      ST_RANK: begin
        if (WCNT_W'(k_q) == w_q - WCNT_W'(1)) begin
          state_d = ST_MED;
        end else begin
          k_d = k_q + idx_t'(1);
        end
      end
      ST_MED: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = med;
          out_raw_d  = 1'b0;
          out_last_d = 1'b0;
          if (last_q) begin
            d_d     = h_q;
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = rd_data;
          out_raw_d  = 1'b1;
          out_last_d = (d_q == idx_t'(1));
          d_d        = d_q - idx_t'(1);
          if (d_q == idx_t'(1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_req_q   <= WIN_W'(MIN_WINDOW);
      fill_q      <= '0;
      out_valid_q <= 1'b0;
      w_q         <= '0;
      k_q         <= '0;
      d_q         <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
      w_q         <= w_d;
      k_q         <= k_d;
      d_q         <= d_d;
      last_q      <= last_d;
      if (cfg_valid_i && cfg_ready_o) begin
        win_req_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_raw_q  <= out_raw_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_raw_q;
  assign m_axis_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
  // exactly one stage of the window holds the median rank
  a_med_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MED) |-> $onehot(match))
    else $error("median rank not unique");

  a_flush_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (d_q != '0))
    else $error("flush with nothing left");

  a_rank_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK) |-> (WCNT_W'(k_q) < w_q))
    else $error("rank broadcast beyond window");

  // a result is only loaded when the output register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
